// ----- sv/box_filter_5x5_zero_pad_defines.svh -----
// Assertion macros shared by the box filter RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef BOX_FILTER_5X5_ZERO_PAD_DEFINES_SVH
`define BOX_FILTER_5X5_ZERO_PAD_DEFINES_SVH

// Same-cycle implication.
`define BF5_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box filter check failed");

// Next-cycle implication.
`define BF5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box filter check failed");

`endif

// ----- sv/bf5_pkg.sv -----
package bf5_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int WINDOW      = 5;
    localparam int HALF        = (WINDOW - 1) / 2;
    localparam int LINES       = WINDOW - 1;
    localparam int AREA        = WINDOW * WINDOW;
    localparam int PIXEL_BITS  = 16;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(LINES);

    // Field and counter widths
    localparam int FW_W        = 12;
    localparam int FH_W        = 16;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 11;
    localparam int SCAN_ROW_W  = 17;
    localparam int SCAN_COL_W  = 12;
    localparam int COLSUM_W    = 19;
    localparam int TOTAL_W     = 21;
    localparam int QUOT_W      = 16;
    localparam int FRAC_W      = 8;
    localparam int REM_W       = 5;
    localparam int AVG_W       = 24;

    // Divide by AREA: quotient = (total * RECIP) >> RECIP_SHIFT, exact for total < 2^21
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP       = 2684355;

    // Register map
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(2048);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(2048);

    // Fraction part for remainder b: floor((256*b + 12) / 25)
    localparam logic [FRAC_W-1:0] FRAC_LUT [AREA] = '{
        8'd0,   8'd10,  8'd20,  8'd31,  8'd41,
        8'd51,  8'd61,  8'd72,  8'd82,  8'd92,
        8'd102, 8'd113, 8'd123, 8'd133, 8'd143,
        8'd154, 8'd164, 8'd174, 8'd184, 8'd195,
        8'd205, 8'd215, 8'd225, 8'd236, 8'd246
    };

    typedef struct packed {
        logic                  kind;
        logic [PIXEL_BITS-1:0] pixel_value;
    } bf5_pix_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg_value;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } bf5_res_t;

endpackage

// ----- sv/bf5_ram.sv -----
module bf5_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read and a write to one address in a cycle return the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/box_filter_5x5_zero_pad.sv -----
// Streaming 5x5 box filter, zero padded, fixed divisor 25, 8 fraction bits.
// A result is carried from its accepted item through the stage 1 to 4 registers and the result register.
// Throughput: one item per clock; the pipeline stalls only while the result is held.
// Reset clears scan position, column sums and pipeline valids, and loads 2048 into
// both size registers. Line buffers are not cleared; no clearing pass is run.
`include "box_filter_5x5_zero_pad_defines.svh"

module box_filter_5x5_zero_pad
    import bf5_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // pixel channel
    input  logic               pix_valid,
    output logic               pix_stall,
    input  bf5_pix_t           pix_data,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output bf5_res_t           res_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Position tag that travels with each item down the pipeline.
    typedef struct packed {
        logic             first;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } tag_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
        endcase
    end

    // Effective sizes: width 0 acts as 1 and is capped at the line length;
    // height 0 acts as 1.
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when the one after it is
    // empty or moving, so bubbles collapse. The chain is combinational: a
    // held result reaches pix_stall in the same cycle once every stage is full.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, res_valid_reg;
    logic free1, free2, free3, free4, free5;
    logic mv1, mv2, mv3, mv4;
    logic acc;

    assign free5 = !res_valid_reg || !res_stall;
    assign mv4   = s4_valid_reg && free5;
    assign free4 = !s4_valid_reg || free5;
    assign mv3   = s3_valid_reg && free4;
    assign free3 = !s3_valid_reg || free4;
    assign mv2   = s2_valid_reg && free3;
    assign free2 = !s2_valid_reg || free3;
    assign mv1   = s1_valid_reg && free2;
    assign free1 = !s1_valid_reg || free2;

    assign acc       = pix_valid && free1;
    assign pix_stall = !free1;

    // ------------------------------------------------------------------
    // Stage 0: scan position over the extended grid, line buffer access
    // ------------------------------------------------------------------
    logic [SCAN_ROW_W-1:0] scan_row_reg, scan_row_next;
    logic [SCAN_COL_W-1:0] scan_col_reg, scan_col_next;
    logic                  row_in, col_in;
    logic                  row_end, frame_end, emit;
    logic [PIXEL_BITS-1:0] cur;
    logic [LINES-1:0]      line_mask;
    logic [LINES-1:0]      line_we;
    logic [SLOT_W:0]       lag;
    logic [SCAN_ROW_W-1:0] row_m;
    logic [SCAN_COL_W-1:0] col_m;
    tag_t                  tag0;

    always_comb
    begin
        row_in    = scan_row_reg < SCAN_ROW_W'(h_eff);
        col_in    = scan_col_reg < w_eff;
        row_end   = (SCAN_COL_W+1)'(scan_col_reg)
                    >= (SCAN_COL_W+1)'(w_eff) + (SCAN_COL_W+1)'(HALF);
        frame_end = row_end && (scan_row_reg >= SCAN_ROW_W'(h_eff) + SCAN_ROW_W'(HALF));
        emit      = (scan_row_reg >= SCAN_ROW_W'(HALF)) && (scan_col_reg >= SCAN_COL_W'(HALF));

        // Positions outside the image read as zero whatever kind says.
        cur = (!pix_data.kind && col_in && row_in) ? pix_data.pixel_value : '0;

        // Buffer k holds row r - lag; keep it only if that row lies in the image.
        for (int k = 0; k < LINES; k++)
        begin
            lag = {1'b0, scan_row_reg[SLOT_W-1:0] - SLOT_W'(k)};
            if (lag == '0)
            begin
                lag = (SLOT_W+1)'(LINES);
            end
            line_mask[k] = col_in && (scan_row_reg >= SCAN_ROW_W'(lag))
                           && ((scan_row_reg - SCAN_ROW_W'(lag)) < SCAN_ROW_W'(h_eff));
            line_we[k]   = acc && col_in && row_in
                           && (scan_row_reg[SLOT_W-1:0] == SLOT_W'(k));
        end

        row_m      = scan_row_reg - SCAN_ROW_W'(HALF);
        col_m      = scan_col_reg - SCAN_COL_W'(HALF);
        tag0.first = scan_col_reg == '0;
        tag0.emit  = emit;
        tag0.last  = frame_end;
        tag0.row   = row_m[ROW_W-1:0];
        tag0.col   = col_m[COL_W-1:0];

        // Advance the scan: wrap at frame end, drop to next row at row end.
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        if (acc)
        begin
            if (frame_end)
            begin
                scan_row_next = '0;
                scan_col_next = '0;
            end
            else if (row_end)
            begin
                scan_row_next = scan_row_reg + SCAN_ROW_W'(1);
                scan_col_next = '0;
            end
            else
            begin
                scan_col_next = scan_col_reg + SCAN_COL_W'(1);
            end
        end
    end

    // Four line buffers, one per earlier row, all read at the current column.
    // The buffer written this cycle returns its old word: the row four above.
    logic [PIXEL_BITS-1:0] line_rd [LINES];

    for (genvar k = 0; k < LINES; k++)
    begin : g_line
        bf5_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (line_we[k]),
            .waddr (scan_col_reg[ADDR_W-1:0]),
            .wdata (cur),
            .re    (acc),
            .raddr (scan_col_reg[ADDR_W-1:0]),
            .rdata (line_rd[k])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: vertical column sum
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] s1_cur_reg;
    logic [LINES-1:0]      s1_mask_reg;
    tag_t                  s1_tag_reg;
    logic [COLSUM_W-1:0]   colsum;

    always_comb
    begin
        colsum = COLSUM_W'(s1_cur_reg);
        for (int k = 0; k < LINES; k++)
        begin
            if (s1_mask_reg[k])
            begin
                colsum = colsum + COLSUM_W'(line_rd[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: horizontal window of column sums
    // ------------------------------------------------------------------
    logic [COLSUM_W-1:0] s2_colsum_reg;
    tag_t                s2_tag_reg;
    logic [COLSUM_W-1:0] cs_reg  [LINES];
    logic [COLSUM_W-1:0] cs_next [LINES];
    logic [TOTAL_W-1:0]  total;

    always_comb
    begin
        total      = TOTAL_W'(s2_colsum_reg);
        cs_next[0] = s2_colsum_reg;
        for (int k = 0; k < LINES; k++)
        begin
            if (!s2_tag_reg.first)
            begin
                total = total + TOTAL_W'(cs_reg[k]);
            end
        end
        // Start of a row clears the window: columns left of the image are zero.
        for (int k = 1; k < LINES; k++)
        begin
            cs_next[k] = s2_tag_reg.first ? '0 : cs_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient by reciprocal multiply
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0]         s3_total_reg;
    tag_t                       s3_tag_reg;
    logic [TOTAL_W+RECIP_W-1:0] prod;

    assign prod = (TOTAL_W+RECIP_W)'(s3_total_reg) * (TOTAL_W+RECIP_W)'(RECIP);

    // ------------------------------------------------------------------
    // Stage 4: remainder and rounded fraction
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0] s4_total_reg;
    logic [QUOT_W-1:0]  s4_quot_reg;
    tag_t               s4_tag_reg;
    logic [TOTAL_W-1:0] rem_full;
    bf5_res_t           res_next;

    always_comb
    begin
        rem_full            = s4_total_reg - TOTAL_W'(s4_quot_reg) * TOTAL_W'(AREA);
        res_next.avg_value  = {s4_quot_reg, FRAC_LUT[rem_full[REM_W-1:0]]};
        res_next.out_row    = s4_tag_reg.row;
        res_next.out_col    = s4_tag_reg.col;
        res_next.frame_last = s4_tag_reg.last;
    end

    bf5_res_t res_reg;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // ------------------------------------------------------------------
    // Valid bits next values
    // ------------------------------------------------------------------
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, res_valid_next;

    always_comb
    begin
        s1_valid_next  = acc || (s1_valid_reg && !mv1);
        s2_valid_next  = mv1 || (s2_valid_reg && !mv2);
        // Items before the window fills stop after the column-sum update.
        s3_valid_next  = (mv2 && s2_tag_reg.emit) || (s3_valid_reg && !mv3);
        s4_valid_next  = mv3 || (s4_valid_reg && !mv4);
        res_valid_next = mv4 || (res_valid_reg && res_stall);
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            scan_row_reg     <= '0;
            scan_col_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            for (int k = 0; k < LINES; k++)
            begin
                cs_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (paddr[2])
                    REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                endcase
            end
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            res_valid_reg <= res_valid_next;
            if (mv2)
            begin
                for (int k = 0; k < LINES; k++)
                begin
                    cs_reg[k] <= cs_next[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load on stage entry, hold otherwise
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cur_reg  <= cur;
            s1_mask_reg <= line_mask;
            s1_tag_reg  <= tag0;
        end
        if (mv1)
        begin
            s2_colsum_reg <= colsum;
            s2_tag_reg    <= s1_tag_reg;
        end
        if (mv2)
        begin
            s3_total_reg <= total;
            s3_tag_reg   <= s2_tag_reg;
        end
        if (mv3)
        begin
            s4_total_reg <= s3_total_reg;
            s4_quot_reg  <= prod[RECIP_SHIFT +: QUOT_W];
            s4_tag_reg   <= s3_tag_reg;
        end
        if (mv4)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BF5_ASSERT_NEXT(a_frame_wrap, acc && frame_end, (scan_row_reg == '0) && (scan_col_reg == '0))
    `BF5_ASSERT_IMP(a_one_line_write, 1'b1, $onehot0(line_we))
    `BF5_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !free3, s2_valid_reg && $stable(s2_colsum_reg))

endmodule
